### sv/tcw_pkg.sv
package tcw_pkg;

  // Default screen geometry
  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 25;

  // Cell layout: attribute in the high byte, character in the low byte
  localparam int CELL_W = 16;

  localparam logic [7:0]        SPACE_CHAR   = 8'h20;
  localparam logic [7:0]        NEWLINE_CHAR = 8'd10;
  localparam logic [7:0]        RETURN_CHAR  = 8'd13;
  localparam logic [7:0]        RESET_ATTR   = 8'h0F;
  localparam logic [CELL_W-1:0] RESET_CELL   = {RESET_ATTR, SPACE_CHAR};

  // Function codes
  localparam logic [1:0] FUNC_PUT   = 2'd0;
  localparam logic [1:0] FUNC_CLEAR = 2'd1;
  localparam logic [1:0] FUNC_READ  = 2'd2;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] char_code;
    logic [4:0] read_row;
    logic [6:0] read_col;
  } in_item_t;

  typedef struct packed {
    logic [6:0]        cursor_col;
    logic [4:0]        cursor_row;
    logic [CELL_W-1:0] cell_value;
    logic              scrolled;
  } out_item_t;

endpackage

### sv/tcw_cell_ram.sv
module tcw_cell_ram #(
  parameter int DEPTH = 2000
) (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [$clog2(DEPTH)-1:0]   wr_addr,
  input  logic [tcw_pkg::CELL_W-1:0] wr_data,
  input  logic                       rd_en,
  input  logic [$clog2(DEPTH)-1:0]   rd_addr,
  output logic [tcw_pkg::CELL_W-1:0] rd_data
);
  import tcw_pkg::*;

  logic [CELL_W-1:0] mem [DEPTH];
  logic [CELL_W-1:0] rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### sv/text_console_writer.sv
// Channel | Ports                          | Handshake
// --------+--------------------------------+---------------------------------------
// input   | start, busy, in_item           | taken at an edge with start & !busy
// result  | out_valid, out_item            | one-cycle strobe, receiver cannot stall
// config  | cfg_valid, cfg_ready, cfg_data | taken at cfg_valid & cfg_ready
//
// A put item that does not scroll gives its result in the next cycle; a read item
// passes the S_READ state first. A scroll rewrites the new bottom row, one cell a cycle,
// and a clear rewrites every cell the same way, since the cell memory has a single
// write port. After reset a clearing pass fills the screen while busy is high; config
// is taken throughout. Scrolling moves a top-row pointer, so no rows are copied.
module text_console_writer #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  tcw_pkg::in_item_t  in_item,
  output logic               out_valid,
  output tcw_pkg::out_item_t out_item,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [7:0]         cfg_data
);
  import tcw_pkg::*;

  localparam int CELLS  = ROWS * COLUMNS;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int COL_W  = $clog2(COLUMNS);
  localparam int ROW_W  = (ROWS > 2) ? $clog2(ROWS) : 1;

  typedef enum logic [1:0] {
    S_INIT,
    S_IDLE,
    S_SWEEP,
    S_READ
  } state_t;

  state_t            state_r, state_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [ROW_W-1:0]  line_r, line_nxt;
  logic [ROW_W-1:0]  top_r, top_nxt;
  logic [7:0]        attr_r;
  logic [ADDR_W-1:0] swp_addr_r, swp_addr_nxt;
  logic [ADDR_W-1:0] swp_end_r, swp_end_nxt;
  logic [CELL_W-1:0] fill_r, fill_nxt;
  logic              rd_ok_r, rd_ok_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         res_r, res_nxt;

  logic              mem_we;
  logic [ADDR_W-1:0] mem_wa;
  logic [CELL_W-1:0] mem_wd;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_ra;
  logic [CELL_W-1:0] mem_rd;

  logic              accept;
  logic              at_last_col;
  logic              at_last_line;
  logic              adv_line;
  logic              read_in_range;

  // Map a screen row and column to a memory address through the top-row pointer
  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                  input logic [ROW_W-1:0] top,
                                                  input logic [COL_W-1:0] col);
    logic [ROW_W:0] phys;
    phys = {1'b0, row} + {1'b0, top};
    if (phys >= (ROW_W+1)'(ROWS)) begin
      phys = phys - (ROW_W+1)'(ROWS);
    end
    return ADDR_W'(phys[ROW_W-1:0]) * ADDR_W'(COLUMNS) + ADDR_W'(col);
  endfunction

  assign accept        = start && (state_r == S_IDLE);
  assign busy          = (state_r != S_IDLE);
  assign out_valid     = out_valid_r;
  assign out_item      = res_r;
  assign cfg_ready     = 1'b1;
  assign at_last_col   = (col_r == COL_W'(COLUMNS - 1));
  assign at_last_line  = (line_r == ROW_W'(ROWS - 1));
  assign read_in_range = (32'(in_item.read_row) < 32'(ROWS)) &&
                         (32'(in_item.read_col) < 32'(COLUMNS));

  // Text attribute register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attr_r <= RESET_ATTR;
    end else if (cfg_valid && cfg_ready) begin
      attr_r <= cfg_data;
    end
  end

  // Sequencer: decode a transaction, drive the memory, sweep rows
  always_comb begin
    state_nxt     = state_r;
    col_nxt       = col_r;
    line_nxt      = line_r;
    top_nxt       = top_r;
    swp_addr_nxt  = swp_addr_r;
    swp_end_nxt   = swp_end_r;
    fill_nxt      = fill_r;
    rd_ok_nxt     = rd_ok_r;
    out_valid_nxt = 1'b0;
    res_nxt       = res_r;
    adv_line      = 1'b0;
    mem_we        = 1'b0;
    mem_wa        = swp_addr_r;
    mem_wd        = fill_r;
    mem_re        = 1'b0;
    mem_ra        = cell_addr(ROW_W'(in_item.read_row), top_r, COL_W'(in_item.read_col));

    case (state_r)
      S_INIT, S_SWEEP: begin
        mem_we = 1'b1;
        if (swp_addr_r == swp_end_r) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = (state_r == S_SWEEP);
        end else begin
          swp_addr_nxt = swp_addr_r + 1'b1;
        end
      end

      S_READ: begin
        res_nxt.cell_value = rd_ok_r ? mem_rd : '0;
        out_valid_nxt      = 1'b1;
        state_nxt          = S_IDLE;
      end

      S_IDLE: begin
        if (accept) begin
          res_nxt.cell_value = '0;
          res_nxt.scrolled   = 1'b0;
          case (in_item.func)
            FUNC_PUT: begin
              if (in_item.char_code == NEWLINE_CHAR) begin
                col_nxt  = '0;
                adv_line = 1'b1;
              end else if (in_item.char_code != RETURN_CHAR) begin
                // Write the character at the cursor, then step right
                mem_we = 1'b1;
                mem_wa = cell_addr(line_r, top_r, col_r);
                mem_wd = {attr_r, in_item.char_code};
                if (at_last_col) begin
                  col_nxt  = '0;
                  adv_line = 1'b1;
                end else begin
                  col_nxt = col_r + 1'b1;
                end
              end
              if (adv_line && at_last_line) begin
                // Scroll: the old top row becomes the blank bottom row
                top_nxt          = (top_r == ROW_W'(ROWS - 1)) ? '0 : top_r + 1'b1;
                swp_addr_nxt     = cell_addr('0, top_r, '0);
                swp_end_nxt      = cell_addr('0, top_r, COL_W'(COLUMNS - 1));
                fill_nxt         = {attr_r, SPACE_CHAR};
                res_nxt.scrolled = 1'b1;
                state_nxt        = S_SWEEP;
              end else begin
                if (adv_line) begin
                  line_nxt = line_r + 1'b1;
                end
                out_valid_nxt = 1'b1;
              end
            end

            FUNC_CLEAR: begin
              col_nxt      = '0;
              line_nxt     = '0;
              top_nxt      = '0;
              swp_addr_nxt = '0;
              swp_end_nxt  = ADDR_W'(CELLS - 1);
              fill_nxt     = {attr_r, SPACE_CHAR};
              state_nxt    = S_SWEEP;
            end

            FUNC_READ: begin
              mem_re    = 1'b1;
              rd_ok_nxt = read_in_range;
              state_nxt = S_READ;
            end

            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
          res_nxt.cursor_col = 7'(col_nxt);
          res_nxt.cursor_row = 5'(line_nxt);
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Hold state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      col_r       <= '0;
      line_r      <= '0;
      top_r       <= '0;
      swp_addr_r  <= '0;
      swp_end_r   <= ADDR_W'(CELLS - 1);
      fill_r      <= RESET_CELL;
      rd_ok_r     <= 1'b0;
      out_valid_r <= 1'b0;
      res_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      col_r       <= col_nxt;
      line_r      <= line_nxt;
      top_r       <= top_nxt;
      swp_addr_r  <= swp_addr_nxt;
      swp_end_r   <= swp_end_nxt;
      fill_r      <= fill_nxt;
      rd_ok_r     <= rd_ok_nxt;
      out_valid_r <= out_valid_nxt;
      res_r       <= res_nxt;
    end
  end

  tcw_cell_ram #(
    .DEPTH (CELLS)
  ) u_cell_ram (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_wa),
    .wr_data (mem_wd),
    .rd_en   (mem_re),
    .rd_addr (mem_ra),
    .rd_data (mem_rd)
  );

endmodule

### tb/tb_text_console_writer.sv
module tb_text_console_writer;
  timeunit 1ns;
  timeprecision 1ps;

  import tcw_pkg::*;

  localparam int SCREEN_COLS    = COLUMNS_DEF;
  localparam int SCREEN_ROWS    = ROWS_DEF;
  localparam int SCREEN_CELLS   = SCREEN_COLS * SCREEN_ROWS;
  localparam int MAX_GAP        = 13;
  localparam int PHASES         = 7;
  localparam int PHASE_ITEMS    = 250;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int REPORT_LIMIT   = 10;

  // Function code that the block leaves unused
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  // Screen, cursor and attribute mirror plus the queue of expected results
  class console_scoreboard;
    logic [CELL_W-1:0] cells [SCREEN_CELLS];
    int unsigned       col;
    int unsigned       row;
    logic [7:0]        attribute;
    out_item_t         expected_q[$];
    int                mismatches;

    function new();
      foreach (cells[i]) cells[i] = RESET_CELL;
      col        = 0;
      row        = 0;
      attribute  = RESET_ATTR;
      mismatches = 0;
    endfunction

    function void set_attribute(logic [7:0] value);
      attribute = value;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void report(string what, out_item_t exp, out_item_t got);
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
        $display({"%0t %s: expected col %0d row %0d cell %h scrolled %b,",
                  " got col %0d row %0d cell %h scrolled %b"},
                 $realtime, what, exp.cursor_col, exp.cursor_row, exp.cell_value,
                 exp.scrolled, got.cursor_col, got.cursor_row, got.cell_value,
                 got.scrolled);
    endfunction

    // Move down one row, or scroll up and blank the bottom row on the last one
    function bit advance_line();
      logic [CELL_W-1:0] blank;
      blank = {attribute, SPACE_CHAR};
      if (row >= SCREEN_ROWS - 1) begin
        for (int i = 0; i < (SCREEN_ROWS - 1) * SCREEN_COLS; i++)
          cells[i] = cells[i + SCREEN_COLS];
        for (int i = 0; i < SCREEN_COLS; i++)
          cells[(SCREEN_ROWS - 1) * SCREEN_COLS + i] = blank;
        return 1'b1;
      end
      row++;
      return 1'b0;
    endfunction

    // Apply one accepted transaction to the mirror and queue its result
    function void note_item(in_item_t it);
      out_item_t exp;
      exp = '0;
      case (it.func)
        FUNC_PUT: begin
          if (it.char_code == NEWLINE_CHAR) begin
            col          = 0;
            exp.scrolled = advance_line();
          end else if (it.char_code != RETURN_CHAR) begin
            cells[row * SCREEN_COLS + col] = {attribute, it.char_code};
            col++;
            if (col >= SCREEN_COLS) begin
              col          = 0;
              exp.scrolled = advance_line();
            end
          end
        end
        FUNC_CLEAR: begin
          foreach (cells[i]) cells[i] = {attribute, SPACE_CHAR};
          col = 0;
          row = 0;
        end
        FUNC_READ: begin
          if (it.read_row < SCREEN_ROWS && it.read_col < SCREEN_COLS)
            exp.cell_value = cells[it.read_row * SCREEN_COLS + it.read_col];
        end
        default: ;
      endcase
      exp.cursor_col = 7'(col);
      exp.cursor_row = 5'(row);
      expected_q.push_back(exp);
    endfunction

    // Compare a result with the oldest expectation
    function void check_result(out_item_t got);
      out_item_t exp;
      if (expected_q.size() == 0) begin
        report("unexpected result", '0, got);
        return;
      end
      exp = expected_q.pop_front();
      if (got.cursor_col !== exp.cursor_col || got.cursor_row !== exp.cursor_row ||
          got.cell_value !== exp.cell_value || got.scrolled !== exp.scrolled)
        report("result mismatch", exp, got);
    endfunction
  endclass

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_item_t  in_item;
  logic      out_valid;
  out_item_t out_item;
  logic      cfg_valid;
  logic      cfg_ready;
  logic [7:0] cfg_data;
  int        idle_cycles;

  console_scoreboard sb = new();

  text_console_writer i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Check every strobed result
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      sb.check_result(out_item);
    end
  end

  // Abort when no transaction moves for too long
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic in_item_t pack_item(logic [1:0] func, logic [7:0] ch,
                                         logic [4:0] rrow, logic [6:0] rcol);
    in_item_t it;
    it.func      = func;
    it.char_code = ch;
    it.read_row  = rrow;
    it.read_col  = rcol;
    return it;
  endfunction

  // Mostly text with newlines, some reads, rare clears and the odd unused code
  function automatic in_item_t random_item(int newline_pct);
    in_item_t it;
    int       pick;
    int       pct;
    it   = pack_item(2'($urandom), 8'($urandom), 5'($urandom), 7'($urandom));
    pick = $urandom_range(0, 999);
    if (pick < 3) begin
      it.func = FUNC_CLEAR;
    end else if (pick < 20) begin
      it.func = FUNC_UNUSED;
    end else if (pick < 220) begin
      it.func = FUNC_READ;
      if ($urandom_range(0, 99) < 85) begin
        it.read_row = 5'($urandom_range(0, SCREEN_ROWS - 1));
        it.read_col = 7'($urandom_range(0, SCREEN_COLS - 1));
      end
    end else begin
      it.func = FUNC_PUT;
      pct     = $urandom_range(0, 99);
      if (pct < newline_pct)
        it.char_code = NEWLINE_CHAR;
      else if (pct < newline_pct + 3)
        it.char_code = RETURN_CHAR;
    end
    return it;
  endfunction

  // Hold start high until the block takes the transaction
  task automatic send_item(in_item_t it, int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy);
    sb.note_item(it);
  endtask

  // Drain outstanding results and let any clear or scroll finish
  task automatic wait_idle();
    start <= 1'b0;
    while (sb.pending() != 0 || busy) @(posedge clk);
  endtask

  task automatic write_attribute(logic [7:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.set_attribute(value);
  endtask

  initial begin
    in_item_t   directed_q[$];
    logic [7:0] phase_attr [PHASES];
    int         newline_pct;
    bit         no_gaps;

    phase_attr = '{8'h00, 8'hFF, 8'h5A, 8'h0F, 8'hA5, 8'h80, 8'h7E};
    rst_n     <= 1'b0;
    start     <= 1'b0;
    in_item   <= '0;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Let the clearing pass after reset complete
    repeat (2) @(posedge clk);
    while (busy) @(posedge clk);

    // Directed: reset contents, field extremes, control characters, bad reads
    directed_q.push_back(pack_item(FUNC_READ, 8'h00, 5'd0, 7'd0));
    directed_q.push_back(pack_item(FUNC_READ, 8'hFF, 5'(SCREEN_ROWS - 1), 7'(SCREEN_COLS - 1)));
    directed_q.push_back(pack_item(FUNC_PUT, 8'h00, 5'd0, 7'd0));
    directed_q.push_back(pack_item(FUNC_PUT, 8'hFF, 5'h1F, 7'h7F));
    directed_q.push_back(pack_item(FUNC_PUT, NEWLINE_CHAR, 5'd0, 7'd0));
    directed_q.push_back(pack_item(FUNC_PUT, RETURN_CHAR, 5'd0, 7'd0));
    directed_q.push_back(pack_item(FUNC_PUT, 8'h41, 5'd0, 7'd0));
    directed_q.push_back(pack_item(FUNC_READ, 8'h00, 5'd0, 7'd0));
    directed_q.push_back(pack_item(FUNC_READ, 8'h00, 5'd0, 7'd1));
    directed_q.push_back(pack_item(FUNC_READ, 8'h00, 5'd1, 7'd0));
    directed_q.push_back(pack_item(FUNC_READ, 8'h00, 5'h1F, 7'h7F));
    directed_q.push_back(pack_item(FUNC_READ, 8'h00, 5'(SCREEN_ROWS), 7'd0));
    directed_q.push_back(pack_item(FUNC_READ, 8'h00, 5'd0, 7'(SCREEN_COLS)));
    directed_q.push_back(pack_item(FUNC_UNUSED, 8'hFF, 5'h1F, 7'h7F));
    directed_q.push_back(pack_item(FUNC_CLEAR, 8'hFF, 5'h1F, 7'h7F));
    directed_q.push_back(pack_item(FUNC_READ, 8'h00, 5'd0, 7'd0));
    directed_q.push_back(pack_item(FUNC_PUT, 8'h7E, 5'd0, 7'd0));
    foreach (directed_q[i]) send_item(directed_q[i], $urandom_range(0, MAX_GAP));

    // Random phases, each with an attribute written at its start and one of three newline densities
    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      if (p == 2 || p == 5)
        write_attribute(8'($urandom));
      else
        write_attribute(phase_attr[p]);
      case (p % 3)
        0:       newline_pct = 30;
        1:       newline_pct = 3;
        default: newline_pct = 12;
      endcase
      no_gaps = (p % 3 == 1);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        send_item(random_item(newline_pct), no_gaps ? 0 : $urandom_range(0, MAX_GAP));
      end
    end

    // Drain and let the last clear or scroll settle
    wait_idle();
    repeat (16) @(posedge clk);
    while (sb.pending() != 0) begin
      void'(sb.expected_q.pop_front());
      sb.report("missing result", '0, '0);
    end
    if (sb.mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

### files.f
sv/tcw_pkg.sv
sv/tcw_cell_ram.sv
sv/text_console_writer.sv
tb/tb_text_console_writer.sv
